### rtl/core/rlm_pkg.sv
// Shared constants and types of the RMS level meter.
package rlm_pkg;

    // Field widths.
    localparam int RAW_W    = 32;
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;
    localparam int ROOT_W   = 16;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int CLAMP_W  = 16;
    localparam int BAR_W    = 8;
    localparam int PROD_W   = CLAMP_W + BAR_W;

    // Block and queue sizing.
    localparam int BLOCK_MAX_DEF = 256;
    localparam int QUEUE_DEPTH   = 2;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 16'd1200;
    localparam logic [BAR_W-1:0]   BAR_RESET   = 8'd40;

    // Register indexes, taken from address bit 2.
    localparam logic REG_CLAMP = 1'b0;
    localparam logic REG_BAR   = 1'b1;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_MUL,
        BK_BDIV,
        BK_DONE
    } back_state_t;

endpackage

### rtl/core/rlm_if.sv
// Valid/ready channel interfaces for samples and results.
interface rlm_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [rlm_pkg::RAW_W-1:0] raw_word;
    logic                            block_end;

    modport source (output valid, output raw_word, output block_end, input ready);
    modport sink   (input valid, input raw_word, input block_end, output ready);
endinterface

interface rlm_out_if;
    logic                        valid;
    logic                        ready;
    logic [rlm_pkg::ROOT_W-1:0]  rms_level;
    logic [rlm_pkg::BAR_W-1:0]   bar_count;

    modport source (output valid, output rms_level, output bar_count, input ready);
    modport sink   (input valid, input rms_level, input bar_count, output ready);
endinterface

### rtl/core/rlm_queue.sv
// Small register queue between the accumulator front and the math back end.
module rlm_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = rlm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/rlm_front.sv
// Sample front end: squares each sample and accumulates the block totals.
module rlm_front #(
    parameter int BLOCK_MAX = rlm_pkg::BLOCK_MAX_DEF,
    parameter int CNT_W     = $clog2(BLOCK_MAX + 1),
    parameter int SUM_W     = rlm_pkg::SQ_W + $clog2(BLOCK_MAX)
) (
    input  logic             clk,
    input  logic             rst_n,
    rlm_in_if.sink           samples,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [SUM_W-1:0] push_sum,
    output logic [CNT_W-1:0] push_count
);
    logic [SUM_W-1:0]                   sum_reg, sum_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic signed [rlm_pkg::SAMPLE_W-1:0] sample;
    logic signed [2*rlm_pkg::SAMPLE_W-1:0] square;
    logic [SUM_W-1:0]                   total;
    logic [CNT_W-1:0]                   count_inc;
    logic                               accept;
    logic                               block_done;

    // The sample is the upper half of the raw word; its square is never negative.
    assign sample    = samples.raw_word[rlm_pkg::RAW_W-1 -: rlm_pkg::SAMPLE_W];
    assign square    = sample * sample;
    assign total     = sum_reg + {{(SUM_W - rlm_pkg::SQ_W){1'b0}}, square[rlm_pkg::SQ_W-1:0]};
    assign count_inc = count_reg + 1'b1;
    assign block_done = samples.block_end || (count_inc == CNT_W'(BLOCK_MAX));

    // A sample is taken whenever the queue has room for a possible block end.
    assign samples.ready = push_ready;
    assign accept        = samples.valid && samples.ready;

    assign push_valid = accept && block_done;
    assign push_sum   = total;
    assign push_count = count_inc;

    // Accumulator update; a finished block restarts from zero.
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            sum_next   = block_done ? '0 : total;
            count_next = block_done ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/rlm_back.sv
// Back end: mean by long division, integer square root, and bar scaling.
module rlm_back #(
    parameter int BLOCK_MAX = rlm_pkg::BLOCK_MAX_DEF,
    parameter int CNT_W     = $clog2(BLOCK_MAX + 1),
    parameter int SUM_W     = rlm_pkg::SQ_W + $clog2(BLOCK_MAX)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  logic [SUM_W-1:0]              pop_sum,
    input  logic [CNT_W-1:0]              pop_count,
    input  logic [rlm_pkg::CLAMP_W-1:0]   clamp_level,
    input  logic [rlm_pkg::BAR_W-1:0]     bar_max,
    rlm_out_if.source                     results
);
    localparam int STEP_W = $clog2(SUM_W);
    localparam int ROOT_W = rlm_pkg::ROOT_W;
    localparam int RAD_W  = rlm_pkg::RAD_W;
    localparam int SREM_W = ROOT_W + 2;
    localparam int CL_W   = rlm_pkg::CLAMP_W;
    localparam int PROD_W = rlm_pkg::PROD_W;
    localparam int BAR_W  = rlm_pkg::BAR_W;

    rlm_pkg::back_state_t state_reg, state_next;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SREM_W-1:0] srem_reg, srem_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CL_W-1:0]   brem_reg, brem_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROOT_W-1:0] rms_out_reg, rms_out_next;
    logic [BAR_W-1:0]  bar_out_reg, bar_out_next;

    logic [CNT_W:0]    div_trial;
    logic              div_ge;
    logic [SREM_W-1:0] sqrt_trial;
    logic [SREM_W-1:0] sqrt_sub;
    logic              sqrt_ge;
    logic [CL_W:0]     bdiv_trial;
    logic              bdiv_ge;
    logic [CL_W-1:0]   clamped;
    logic              out_free;

    // One restoring step of the mean division.
    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, div_reg});

    // One digit of the square root.
    assign sqrt_trial = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign sqrt_sub   = {root_reg, 2'b01};
    assign sqrt_ge    = (sqrt_trial >= sqrt_sub);

    // One restoring step of the bar division.
    assign bdiv_trial = {brem_reg, prod_reg[PROD_W-1]};
    assign bdiv_ge    = (bdiv_trial >= {1'b0, clamp_level});

    assign clamped  = (root_reg < clamp_level) ? root_reg : clamp_level;
    assign out_free = !out_valid_reg || results.ready;

    assign pop_ready         = (state_reg == rlm_pkg::BK_IDLE);
    assign results.valid     = out_valid_reg;
    assign results.rms_level = rms_out_reg;
    assign results.bar_count = bar_out_reg;

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        prod_next      = prod_reg;
        brem_next      = brem_reg;
        out_valid_next = out_valid_reg;
        rms_out_next   = rms_out_reg;
        bar_out_next   = bar_out_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rlm_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    quo_next   = pop_sum;
                    div_next   = pop_count;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = rlm_pkg::BK_DIV;
                end
            end
            rlm_pkg::BK_DIV:
            begin
                rem_next  = div_ge ? CNT_W'(div_trial - {1'b0, div_reg})
                                   : div_trial[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    step_next  = '0;
                    state_next = rlm_pkg::BK_SQRT;
                end
            end
            rlm_pkg::BK_SQRT:
            begin
                // The mean of squares never exceeds one full-scale square.
                if (step_reg == '0)
                begin
                    rad_next  = {1'b0, quo_reg[rlm_pkg::SQ_W-1:0]};
                    root_next = '0;
                    srem_next = '0;
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    srem_next = sqrt_ge ? (sqrt_trial - sqrt_sub) : sqrt_trial;
                    root_next = {root_reg[ROOT_W-2:0], sqrt_ge};
                    rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_W'(ROOT_W))
                    begin
                        step_next  = '0;
                        state_next = rlm_pkg::BK_MUL;
                    end
                end
            end
            rlm_pkg::BK_MUL:
            begin
                prod_next  = clamped * bar_max;
                brem_next  = '0;
                step_next  = '0;
                state_next = rlm_pkg::BK_BDIV;
            end
            rlm_pkg::BK_BDIV:
            begin
                brem_next = bdiv_ge ? CL_W'(bdiv_trial - {1'b0, clamp_level})
                                    : bdiv_trial[CL_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], bdiv_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(PROD_W - 1))
                begin
                    step_next  = '0;
                    state_next = rlm_pkg::BK_DONE;
                end
            end
            rlm_pkg::BK_DONE:
            begin
                // Hold the result until the output register is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rms_out_next   = root_reg;
                    bar_out_next   = (clamp_level == '0) ? '0 : prod_reg[BAR_W-1:0];
                    state_next     = rlm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rlm_pkg::BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rlm_pkg::BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        srem_reg    <= srem_next;
        prod_reg    <= prod_next;
        brem_reg    <= brem_next;
        rms_out_reg <= rms_out_next;
        bar_out_reg <= bar_out_next;
    end

endmodule

### rtl/core/block_rms_level_meter.sv
// After a block's last sample, its totals pass through the block queue to the back end, whose
// one-bit-per-cycle divide, root and bar divide produce the result in the output register.
// Throughput: one sample per cycle while the queue has room; the back end takes a block only
// when idle, and samples stall when the two-entry block queue fills behind shorter blocks.
// Reset clears the accumulator, count, queue and output valid, and loads clamp_level 1200
// and bar_max 40.
module block_rms_level_meter #(
    parameter int BLOCK_MAX = rlm_pkg::BLOCK_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlm_pkg::ADDR_W-1:0]    paddr,
    input  logic [rlm_pkg::DATA_W-1:0]    pwdata,
    output logic [rlm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    rlm_in_if.sink                        samples,
    rlm_out_if.source                     results
);
    localparam int CNT_W = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W = rlm_pkg::SQ_W + $clog2(BLOCK_MAX);

    logic [rlm_pkg::CLAMP_W-1:0] clamp_reg, clamp_next;
    logic [rlm_pkg::BAR_W-1:0]   bar_reg, bar_next;
    logic                        wr_en;

    logic             push_valid;
    logic             push_ready;
    logic [SUM_W-1:0] push_sum;
    logic [CNT_W-1:0] push_count;
    logic             pop_valid;
    logic             pop_ready;
    logic [SUM_W-1:0] pop_sum;
    logic [CNT_W-1:0] pop_count;

    // Configuration registers, decoded on the word address.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        clamp_next = clamp_reg;
        bar_next   = bar_reg;
        if (wr_en)
        begin
            case (paddr[2])
                rlm_pkg::REG_CLAMP: clamp_next = pwdata[rlm_pkg::CLAMP_W-1:0];
                rlm_pkg::REG_BAR:   bar_next   = pwdata[rlm_pkg::BAR_W-1:0];
                default:            clamp_next = clamp_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            rlm_pkg::REG_CLAMP: prdata = {{(rlm_pkg::DATA_W - rlm_pkg::CLAMP_W){1'b0}}, clamp_reg};
            rlm_pkg::REG_BAR:   prdata = {{(rlm_pkg::DATA_W - rlm_pkg::BAR_W){1'b0}}, bar_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg <= rlm_pkg::CLAMP_RESET;
            bar_reg   <= rlm_pkg::BAR_RESET;
        end
        else
        begin
            clamp_reg <= clamp_next;
            bar_reg   <= bar_next;
        end
    end

    // Accumulating front end.
    rlm_front #(
        .BLOCK_MAX (BLOCK_MAX),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sum   (push_sum),
        .push_count (push_count)
    );

    // Queue of finished block totals.
    rlm_queue #(
        .WIDTH (SUM_W + CNT_W),
        .DEPTH (rlm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_sum, push_count}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   ({pop_sum, pop_count})
    );

    // Mean, root and bar computation.
    rlm_back #(
        .BLOCK_MAX (BLOCK_MAX),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_sum     (pop_sum),
        .pop_count   (pop_count),
        .clamp_level (clamp_reg),
        .bar_max     (bar_reg),
        .results     (results)
    );

endmodule
